[design/orthogonal_connector_router_defines.svh]
// assertion macros used by the checker file of the connector router
`ifndef ORTHOGONAL_CONNECTOR_ROUTER_DEFINES_SVH
`define ORTHOGONAL_CONNECTOR_ROUTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define OCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define OCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ocr_pkg.sv]
// shared types, constants and helpers of the orthogonal connector router
package ocr_pkg;

  localparam int COORD_BITS    = 24;
  localparam int FRAC_BITS     = 8;
  localparam int SEGMENT_COUNT = 5;
  localparam int RANK_BITS     = 6;
  localparam int THICK_BITS    = 16;
  localparam int PITCH_BITS    = 12;
  localparam int STUB_BITS     = 12;
  localparam int SEG_IDX_BITS  = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [THICK_BITS-1:0] THICK_RESET = THICK_BITS'(256);
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(256);
  localparam logic [STUB_BITS-1:0]  STUB_RESET  = STUB_BITS'(512);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LINE_THICKNESS = 2'd0,
    CFG_RANK_PITCH     = 2'd1,
    CFG_STUB_LENGTH    = 2'd2
  } cfg_reg_e;

  typedef enum logic [SEG_IDX_BITS-1:0] {
    SEG_SRC_STUB = 3'd0,
    SEG_SRC_RISE = 3'd1,
    SEG_CHANNEL  = 3'd2,
    SEG_DST_RISE = 3'd3,
    SEG_DST_STUB = 3'd4
  } seg_e;

  localparam seg_e SEG_LAST = SEG_DST_STUB;

  // slots of the corner point bundle passed to the serializer
  typedef enum logic [2:0] {
    PT_SX  = 3'd0,
    PT_SY  = 3'd1,
    PT_DX  = 3'd2,
    PT_DY  = 3'd3,
    PT_EX  = 3'd4,
    PT_WX  = 3'd5,
    PT_ROW = 3'd6
  } pt_e;

  localparam int PT_COUNT = 7;

  typedef struct packed {
    logic [THICK_BITS-1:0] line_thickness;
    logic [PITCH_BITS-1:0] rank_pitch;
    logic [STUB_BITS-1:0]  stub_length;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] src_x;
    logic signed [COORD_BITS-1:0] src_y;
    logic        [RANK_BITS-1:0]  src_rank;
    logic signed [COORD_BITS-1:0] src_box_top;
    logic        [COORD_BITS-2:0] src_box_height;
    logic signed [COORD_BITS-1:0] dst_x;
    logic signed [COORD_BITS-1:0] dst_y;
    logic        [RANK_BITS-1:0]  dst_rank;
    logic signed [COORD_BITS-1:0] dst_box_top;
    logic        [COORD_BITS-2:0] dst_box_height;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]   rect_x;
    logic signed [COORD_BITS-1:0]   rect_y;
    logic        [COORD_BITS-1:0]   rect_w;
    logic        [COORD_BITS-1:0]   rect_h;
    logic        [SEG_IDX_BITS-1:0] segment_index;
    logic                           last;
  } out_item_t;

  // internal point width: widest of a coordinate and the rank fan, plus headroom
  function automatic int point_bits(input int frac);
    int step_w;
    int max_w;
    step_w = RANK_BITS + 1 + PITCH_BITS + THICK_BITS - frac;
    max_w  = (COORD_BITS > step_w) ? COORD_BITS : step_w;
    return max_w + 5;
  endfunction

  localparam int POINT_BITS = point_bits(FRAC_BITS);

endpackage

[design/ocr_cfg.sv]
// configuration registers of the connector router
module ocr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ocr_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ocr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output ocr_pkg::cfg_t                      cfg_o
);
  import ocr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LINE_THICKNESS: begin
          cfg_d.line_thickness = cfg_data_i[THICK_BITS-1:0];
        end
        CFG_RANK_PITCH: begin
          cfg_d.rank_pitch = cfg_data_i[PITCH_BITS-1:0];
        end
        CFG_STUB_LENGTH: begin
          cfg_d.stub_length = cfg_data_i[STUB_BITS-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_thickness <= THICK_RESET;
      cfg_q.rank_pitch     <= PITCH_RESET;
      cfg_q.stub_length    <= STUB_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/ocr_geom.sv]
// four-stage pipeline that finds the corner points of one wire
module ocr_geom #(
  parameter int FracBits  = ocr_pkg::FRAC_BITS,
  parameter int PointBits = ocr_pkg::POINT_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  ocr_pkg::in_item_t                            in_item_i,
  input  ocr_pkg::cfg_t                                cfg_i,
  output logic                                         geo_valid_o,
  input  logic                                         geo_ready_i,
  output logic [ocr_pkg::PT_COUNT-1:0][PointBits-1:0]  geo_pts_o
);
  import ocr_pkg::*;

  localparam int StubPrdW = STUB_BITS + THICK_BITS;
  localparam int StubW    = StubPrdW - FracBits;
  localparam int PrdW     = PITCH_BITS + THICK_BITS;
  localparam int RsumW    = RANK_BITS + 1;
  localparam int StepPrdW = RsumW + PrdW;

  typedef logic signed [PointBits-1:0] pt_t;

  typedef struct packed {
    pt_t  sx;
    pt_t  sy;
    pt_t  dx;
    pt_t  dy;
    pt_t  st;
    pt_t  dt;
    pt_t  sb;
    pt_t  db;
    pt_t  hsum;
    pt_t  stub;
    pt_t  step;
    logic turn_sub;
    logic turn_add;
    logic back;
  } s2_t;

  typedef struct packed {
    pt_t  sx;
    pt_t  sy;
    pt_t  dx;
    pt_t  dy;
    pt_t  st;
    pt_t  dt;
    pt_t  step;
    pt_t  mid_raw;
    pt_t  ex_b;
    pt_t  wx_b;
    pt_t  ha;
    pt_t  hb;
    pt_t  bot;
    pt_t  stst;
    logic above;
    logic below;
    logic back;
  } s3_t;

  // handshake chain
  logic s1_valid_q, s2_valid_q, s3_valid_q, g_valid_q;
  logic s1_ready, s2_ready, s3_ready, g_ready;

  assign g_ready     = !g_valid_q || geo_ready_i;
  assign s3_ready    = !s3_valid_q || g_ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_stall_o  = !s1_ready;
  assign geo_valid_o = g_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      g_valid_q  <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (g_ready)  g_valid_q  <= s3_valid_q;
    end
  end

  // stage 1: register the ends, rank sum, stub length and pitch times thickness
  in_item_t            s1_in_q;
  logic [StubW-1:0]    s1_stub_q, s1_stub_d;
  logic [PrdW-1:0]     s1_rpt_q, s1_rpt_d;
  logic [RsumW-1:0]    s1_rsum_q, s1_rsum_d;
  logic [StubPrdW-1:0] stub_prd;

  assign stub_prd  = cfg_i.stub_length * cfg_i.line_thickness;
  assign s1_stub_d = stub_prd[StubPrdW-1:FracBits];
  assign s1_rpt_d  = cfg_i.rank_pitch * cfg_i.line_thickness;
  assign s1_rsum_d = {1'b0, in_item_i.src_rank} + {1'b0, in_item_i.dst_rank};

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_in_q   <= in_item_i;
      s1_stub_q <= s1_stub_d;
      s1_rpt_q  <= s1_rpt_d;
      s1_rsum_q <= s1_rsum_d;
    end
  end

  // stage 2: rank fan, box bottoms, directions, backward test
  s2_t                 s2_q, s2_d;
  logic [StepPrdW-1:0] step_prd;
  pt_t                 dxs, dys;
  logic                dx_neg, dx_pos, dy_neg, dy_pos;

  assign step_prd = s1_rsum_q * s1_rpt_q;

  always_comb begin
    s2_d.sx   = pt_t'($signed(s1_in_q.src_x));
    s2_d.sy   = pt_t'($signed(s1_in_q.src_y));
    s2_d.dx   = pt_t'($signed(s1_in_q.dst_x));
    s2_d.dy   = pt_t'($signed(s1_in_q.dst_y));
    s2_d.st   = pt_t'($signed(s1_in_q.src_box_top));
    s2_d.dt   = pt_t'($signed(s1_in_q.dst_box_top));
    s2_d.sb   = s2_d.st + pt_t'({1'b0, s1_in_q.src_box_height});
    s2_d.db   = s2_d.dt + pt_t'({1'b0, s1_in_q.dst_box_height});
    s2_d.hsum = (s2_d.sx + s2_d.dx) >>> 1;
    s2_d.stub = pt_t'({1'b0, s1_stub_q});
    s2_d.step = pt_t'({1'b0, step_prd[StepPrdW-1:FracBits]});
    dxs       = s2_d.dx - s2_d.sx;
    dys       = s2_d.dy - s2_d.sy;
    dx_neg    = dxs[PointBits-1];
    dx_pos    = !dx_neg && (|dxs);
    dy_neg    = dys[PointBits-1];
    dy_pos    = !dy_neg && (|dys);
    // fan moves against the product of the two direction signs
    s2_d.turn_sub = (dx_pos && dy_pos) || (dx_neg && dy_neg);
    s2_d.turn_add = (dx_pos && dy_neg) || (dx_neg && dy_pos);
    s2_d.back     = dxs < (s2_d.stub <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) s2_q <= s2_d;
  end

  // stage 3: candidate columns and channel row terms
  s3_t s3_q, s3_d;

  always_comb begin
    s3_d.sx   = s2_q.sx;
    s3_d.sy   = s2_q.sy;
    s3_d.dx   = s2_q.dx;
    s3_d.dy   = s2_q.dy;
    s3_d.st   = s2_q.st;
    s3_d.dt   = s2_q.dt;
    s3_d.step = s2_q.step;
    s3_d.back = s2_q.back;
    if (s2_q.turn_sub) begin
      s3_d.mid_raw = s2_q.hsum - s2_q.step;
    end else if (s2_q.turn_add) begin
      s3_d.mid_raw = s2_q.hsum + s2_q.step;
    end else begin
      s3_d.mid_raw = s2_q.hsum;
    end
    s3_d.ex_b  = s2_q.sx + s2_q.stub + s2_q.step;
    s3_d.wx_b  = s2_q.dx - s2_q.stub - s2_q.step;
    s3_d.ha    = (s2_q.sb + s2_q.dt) >>> 1;
    s3_d.hb    = (s2_q.db + s2_q.st) >>> 1;
    s3_d.bot   = (s2_q.sb > s2_q.db) ? s2_q.sb : s2_q.db;
    s3_d.stst  = s2_q.stub + s2_q.step;
    s3_d.above = s2_q.sb <= s2_q.dt;
    s3_d.below = s2_q.db <= s2_q.st;
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) s3_q <= s3_d;
  end

  // stage 4: clamp the middle column, pick the channel row
  logic [PT_COUNT-1:0][PointBits-1:0] g_pts_q, g_pts_d;
  pt_t lo_x, hi_x, mid_a, mid, ra, rb, rc, row_b;

  always_comb begin
    lo_x  = (s3_q.sx < s3_q.dx) ? s3_q.sx : s3_q.dx;
    hi_x  = (s3_q.sx > s3_q.dx) ? s3_q.sx : s3_q.dx;
    mid_a = (s3_q.mid_raw > lo_x) ? s3_q.mid_raw : lo_x;
    mid   = (mid_a < hi_x) ? mid_a : hi_x;
    ra    = s3_q.ha + s3_q.step;
    rb    = s3_q.hb + s3_q.step;
    rc    = s3_q.bot + s3_q.stst;
    if (s3_q.above) begin
      row_b = (ra < s3_q.dt) ? ra : s3_q.dt;
    end else if (s3_q.below) begin
      row_b = (rb < s3_q.st) ? rb : s3_q.st;
    end else begin
      row_b = rc;
    end
    g_pts_d         = '0;
    g_pts_d[PT_SX]  = s3_q.sx;
    g_pts_d[PT_SY]  = s3_q.sy;
    g_pts_d[PT_DX]  = s3_q.dx;
    g_pts_d[PT_DY]  = s3_q.dy;
    g_pts_d[PT_EX]  = s3_q.back ? s3_q.ex_b : mid;
    g_pts_d[PT_WX]  = s3_q.back ? s3_q.wx_b : mid;
    g_pts_d[PT_ROW] = s3_q.back ? row_b : s3_q.dy;
  end

  always_ff @(posedge clk_i) begin
    if (g_ready) g_pts_q <= g_pts_d;
  end

  assign geo_pts_o = g_pts_q;

endmodule

[design/ocr_serial.sv]
// walks the five segments of a wire and registers one rectangle per cycle while the output is not stalled
module ocr_serial #(
  parameter int PointBits = ocr_pkg::POINT_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         geo_valid_i,
  output logic                                         geo_ready_o,
  input  logic [ocr_pkg::PT_COUNT-1:0][PointBits-1:0]  geo_pts_i,
  input  logic [ocr_pkg::THICK_BITS-1:0]               thickness_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output ocr_pkg::out_item_t                           out_item_o
);
  import ocr_pkg::*;

  localparam int C = COORD_BITS;

  typedef logic signed [PointBits-1:0] pt_t;

  function automatic logic [C-1:0] sat_s(input pt_t v);
    pt_t smax;
    pt_t smin;
    smax = pt_t'({1'b0, {(C-1){1'b1}}});
    smin = -smax - pt_t'(1);
    if (v > smax) return smax[C-1:0];
    if (v < smin) return smin[C-1:0];
    return v[C-1:0];
  endfunction

  function automatic logic [C-1:0] sat_u(input pt_t v);
    pt_t umax;
    umax = pt_t'({1'b0, {C{1'b1}}});
    if (v[PointBits-1]) return '0;
    if (v > umax) return umax[C-1:0];
    return v[C-1:0];
  endfunction

  logic                               seg_valid_q, seg_valid_d;
  seg_e                               cnt_q, cnt_d;
  logic [PT_COUNT-1:0][PointBits-1:0] pts_q;
  logic                               out_valid_q, out_valid_d;
  out_item_t                          out_q, out_d;
  logic                               out_ready, emit, done, load;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign emit        = seg_valid_q && out_ready;
  assign done        = emit && (cnt_q == SEG_LAST);
  assign geo_ready_o = !seg_valid_q || done;
  assign load        = geo_valid_i && geo_ready_o;

  always_comb begin
    seg_valid_d = seg_valid_q;
    cnt_d       = cnt_q;
    if (load) begin
      seg_valid_d = 1'b1;
      cnt_d       = SEG_SRC_STUB;
    end else if (done) begin
      seg_valid_d = 1'b0;
    end else if (emit) begin
      cnt_d = seg_e'(cnt_q + 1'b1);
    end
    out_valid_d = out_ready ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      cnt_q       <= SEG_SRC_STUB;
      out_valid_q <= 1'b0;
    end else begin
      seg_valid_q <= seg_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) pts_q <= geo_pts_i;
  end

  // segment end points and inflated rectangle
  pt_t sx, sy, dx, dy, ex, wx, row;
  pt_t ax, ay, bx, by;
  pt_t x_lo, x_hi, y_lo, y_hi, half, thick;

  always_comb begin
    sx    = $signed(pts_q[PT_SX]);
    sy    = $signed(pts_q[PT_SY]);
    dx    = $signed(pts_q[PT_DX]);
    dy    = $signed(pts_q[PT_DY]);
    ex    = $signed(pts_q[PT_EX]);
    wx    = $signed(pts_q[PT_WX]);
    row   = $signed(pts_q[PT_ROW]);
    thick = pt_t'({1'b0, thickness_i});
    half  = pt_t'({1'b0, thickness_i[THICK_BITS-1:1]});
    case (cnt_q)
      SEG_SRC_STUB: begin
        ax = sx; ay = sy; bx = ex; by = sy;
      end
      SEG_SRC_RISE: begin
        ax = ex; ay = sy; bx = ex; by = row;
      end
      SEG_CHANNEL: begin
        ax = ex; ay = row; bx = wx; by = row;
      end
      SEG_DST_RISE: begin
        ax = wx; ay = row; bx = wx; by = dy;
      end
      SEG_DST_STUB: begin
        ax = wx; ay = dy; bx = dx; by = dy;
      end
      default: begin
        ax = '0; ay = '0; bx = '0; by = '0;
      end
    endcase
    x_lo = (ax < bx) ? ax : bx;
    x_hi = (ax < bx) ? bx : ax;
    y_lo = (ay < by) ? ay : by;
    y_hi = (ay < by) ? by : ay;
    out_d.rect_x        = sat_s(x_lo - half);
    out_d.rect_y        = sat_s(y_lo - half);
    out_d.rect_w        = sat_u(x_hi - x_lo + thick);
    out_d.rect_h        = sat_u(y_hi - y_lo + thick);
    out_d.segment_index = cnt_q;
    out_d.last          = (cnt_q == SEG_LAST);
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/orthogonal_connector_router.sv]
// top level of the orthogonal connector router
// Takes one wire (two port ends with their node boxes) per input transfer and
// returns five rectangle transfers, source side first, the fifth with last set.
// Rectangles leave one per cycle while the output is not stalled: the segment
// serializer has one output register, emits one segment a cycle when not
// stalled and loads the next wire as it emits the last segment. The corner
// points come from a four-stage pipeline (products, fan and bottoms,
// candidates, clamp and row select), so up to six wires are in flight (four in
// the pipeline, one in the serializer, the last rectangle of one more in the
// output register), a wire going through them in that order. The configuration
// port always accepts; write it only while no wire is in flight.
module orthogonal_connector_router #(
  parameter int FracBits = ocr_pkg::FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ocr_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ocr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ocr_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ocr_pkg::out_item_t                 out_item_o
);
  import ocr_pkg::*;

  localparam int PointBits = point_bits(FracBits);

  cfg_t                               cfg;
  logic                               geo_valid, geo_ready;
  logic [PT_COUNT-1:0][PointBits-1:0] geo_pts;

  ocr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ocr_geom #(
    .FracBits  (FracBits),
    .PointBits (PointBits)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .geo_valid_o (geo_valid),
    .geo_ready_i (geo_ready),
    .geo_pts_o   (geo_pts)
  );

  ocr_serial #(
    .PointBits (PointBits)
  ) u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geo_valid_i (geo_valid),
    .geo_ready_o (geo_ready),
    .geo_pts_i   (geo_pts),
    .thickness_i (cfg.line_thickness),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/ocr_checker.sv]
// port-level checks of the connector router and their bind
`include "orthogonal_connector_router_defines.svh"

module ocr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input ocr_pkg::in_item_t                  in_item_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input ocr_pkg::out_item_t                 out_item_o
);
  import ocr_pkg::*;

  // a stalled wire stays put on the input
  `OCR_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i), "wire changed while stalled")

  // a stalled rectangle stays put
  `OCR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "rectangle changed while stalled")

  // last marks exactly the final segment
  `OCR_ASSERT_NOW(a_last_flag, out_valid_o, out_item_o.last == (out_item_o.segment_index == SEG_LAST), "last flag does not match segment index")

  // segments of one wire come back to back in order
  `OCR_ASSERT_NEXT(a_seg_follow, out_valid_o && !out_stall_i && !out_item_o.last, out_valid_o && (out_item_o.segment_index == $past(out_item_o.segment_index) + 3'd1), "segment missing or out of order")

  // a new wire starts at the source side
  `OCR_ASSERT_NEXT(a_seg_restart, out_valid_o && !out_stall_i && out_item_o.last, !out_valid_o || (out_item_o.segment_index == SEG_SRC_STUB), "wire does not start at segment zero")

endmodule

bind orthogonal_connector_router ocr_checker u_ocr_checker (.*);

[bench/tb_top.sv]
// self-checking bench for the orthogonal connector router: directed and random wires
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ocr_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-2:0] height_t;
  typedef logic        [RANK_BITS-1:0]  rank_t;
  typedef logic        [CFG_DATA_BITS-1:0] cfg_word_t;

  localparam longint PX         = 256;
  localparam longint COORD_MAX  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;
  localparam longint EXTENT_MAX = (longint'(1) <<< COORD_BITS) - 1;
  localparam longint HEIGHT_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint SPAN       = 64 * PX;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  cfg_word_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  // register copies used by the predictor
  logic [THICK_BITS-1:0] thick_cfg = THICK_RESET;
  logic [PITCH_BITS-1:0] pitch_cfg = PITCH_RESET;
  logic [STUB_BITS-1:0]  stub_cfg  = STUB_RESET;

  out_item_t pending_rects[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  int holdoff_left = 0;

  orthogonal_connector_router uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint lesser(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint greater(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // arithmetic shift rounds toward minus infinity
  function automatic longint floor_half(input longint v);
    return v >>> 1;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    return coord_t'(greater(lesser(v, COORD_MAX), COORD_MIN));
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_extent(input longint v);
    return COORD_BITS'(greater(lesser(v, EXTENT_MAX), 0));
  endfunction

  // works out the five segment rectangles of one wire and queues them
  function automatic void route_wire(input in_item_t w);
    longint sx, sy, st, sh, dx, dy, dt, dh;
    longint t, half, stub, step, mid, ex, wx, row, sb, db;
    longint px[6];
    longint py[6];
    out_item_t r;
    sx = longint'($signed(w.src_x));
    sy = longint'($signed(w.src_y));
    st = longint'($signed(w.src_box_top));
    sh = longint'(w.src_box_height);
    dx = longint'($signed(w.dst_x));
    dy = longint'($signed(w.dst_y));
    dt = longint'($signed(w.dst_box_top));
    dh = longint'(w.dst_box_height);
    t = longint'(thick_cfg);
    half = t >>> 1;
    stub = (longint'(stub_cfg) * t) >>> FRAC_BITS;
    step = ((longint'(w.src_rank) + longint'(w.dst_rank)) * longint'(pitch_cfg) * t)
           >>> FRAC_BITS;
    mid = floor_half(sx + dx) - sign_of(dy - sy) * sign_of(dx - sx) * step;
    mid = lesser(greater(mid, lesser(sx, dx)), greater(sx, dx));
    if ((dx - sx) < 2 * stub) begin
      ex = sx + stub + step;
      wx = dx - stub - step;
      sb = st + sh;
      db = dt + dh;
      if (sb <= dt) begin
        row = lesser(floor_half(sb + dt) + step, dt);
      end else if (db <= st) begin
        row = lesser(floor_half(db + st) + step, st);
      end else begin
        // boxes overlap vertically: run below both
        row = greater(sb, db) + stub + step;
      end
    end else begin
      ex = mid;
      wx = mid;
      row = dy;
    end
    px = '{sx, ex, ex, wx, wx, dx};
    py = '{sy, sy, row, row, dy, dy};
    for (int k = 0; k < SEGMENT_COUNT; k++) begin
      r.rect_x = clamp_coord(lesser(px[k], px[k+1]) - half);
      r.rect_y = clamp_coord(lesser(py[k], py[k+1]) - half);
      r.rect_w = clamp_extent(greater(px[k], px[k+1]) - lesser(px[k], px[k+1]) + t);
      r.rect_h = clamp_extent(greater(py[k], py[k+1]) - lesser(py[k], py[k+1]) + t);
      r.segment_index = SEG_IDX_BITS'(k);
      r.last = (SEG_IDX_BITS'(k) == SEG_LAST);
      pending_rects.push_back(r);
    end
  endfunction

  function automatic in_item_t make_wire(input longint sx, input longint sy, input longint sr,
                                         input longint st, input longint sh, input longint dx,
                                         input longint dy, input longint dr, input longint dt,
                                         input longint dh);
    in_item_t w;
    w.src_x = coord_t'(sx);
    w.src_y = coord_t'(sy);
    w.src_rank = rank_t'(sr);
    w.src_box_top = coord_t'(st);
    w.src_box_height = height_t'(sh);
    w.dst_x = coord_t'(dx);
    w.dst_y = coord_t'(dy);
    w.dst_rank = rank_t'(dr);
    w.dst_box_top = coord_t'(dt);
    w.dst_box_height = height_t'(dh);
    return w;
  endfunction

  function automatic longint spread(input longint range_v);
    return longint'($urandom_range(0, 32'(2 * range_v))) - range_v;
  endfunction

  // mostly nearby ends with boxes around them, a quarter fully random bits
  function automatic in_item_t random_wire();
    longint sx, sy, dx, dy;
    if ($urandom_range(0, 3) == 0) begin
      return make_wire(longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom));
    end
    sx = spread(longint'(1) <<< 21);
    sy = spread(longint'(1) <<< 21);
    dx = sx + spread(SPAN);
    dy = sy + spread(SPAN);
    return make_wire(sx, sy, $urandom_range(0, 63),
                     sy - $urandom_range(0, 32'(16 * PX)), $urandom_range(0, 32'(32 * PX)),
                     dx, dy, $urandom_range(0, 63),
                     dy - $urandom_range(0, 32'(16 * PX)), $urandom_range(0, 32'(32 * PX)));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_wire(input in_item_t w);
    while (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    route_wire(w);
    @(negedge clk_i);
  endtask

  task automatic await_rects();
    in_valid_i <= 1'b0;
    while (pending_rects.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input cfg_word_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LINE_THICKNESS: thick_cfg = data;
      CFG_RANK_PITCH:     pitch_cfg = data[PITCH_BITS-1:0];
      CFG_STUB_LENGTH:    stub_cfg = data[STUB_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_router_config(input cfg_word_t thick, input cfg_word_t pitch,
                                   input cfg_word_t stub);
    await_rects();
    write_reg(CFG_LINE_THICKNESS, thick);
    write_reg(CFG_RANK_PITCH, pitch);
    write_reg(CFG_STUB_LENGTH, stub);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_routes();
    // forward wires going down, up and level
    send_wire(make_wire(0, 0, 3, -10*PX, 20*PX, 100*PX, 40*PX, 2, 30*PX, 20*PX));
    send_wire(make_wire(0, 0, 3, -10*PX, 20*PX, 100*PX, -40*PX, 2, -50*PX, 20*PX));
    send_wire(make_wire(0, 0, 5, -10*PX, 20*PX, 100*PX, 0, 5, -10*PX, 20*PX));
    // exactly two stubs apart is forward, one less is backward
    send_wire(make_wire(-5*PX, 0, 0, -PX, 2*PX, -5*PX + 1024, 7*PX, 0, 6*PX, PX));
    send_wire(make_wire(-5*PX, 0, 0, -PX, 2*PX, -5*PX + 1023, 7*PX, 0, 6*PX, PX));
    // both ends on the same point
    send_wire(make_wire(777, -333, 0, -400, 100, 777, -333, 0, -400, 100));
    // rank fan wider than the span, middle column clamps
    send_wire(make_wire(0, 0, 63, -PX, 2*PX, 2000, 1000, 63, 900, 2*PX));
    // backward, source box above, row pulled up to the target top
    send_wire(make_wire(50*PX, 0, 10, -10*PX, 15*PX, 0, 40*PX, 10, 30*PX, 20*PX));
    // backward, target box above
    send_wire(make_wire(50*PX, 40*PX, 0, 30*PX, 20*PX, 0, 0, 0, -10*PX, 15*PX));
    // backward, boxes overlap
    send_wire(make_wire(50*PX, 5*PX, 4, 0, 20*PX, 0, 8*PX, 1, 3*PX, 30*PX));
    // odd negative sum in the channel midpoint
    send_wire(make_wire(0, -1100, 0, -1001, 0, -PX, 50, 0, -2, 10));
    // coordinate and extent saturation
    send_wire(make_wire(COORD_MAX, COORD_MAX, 63, COORD_MAX, HEIGHT_MAX,
                        COORD_MIN, COORD_MIN, 63, COORD_MIN, HEIGHT_MAX));
    send_wire(make_wire(COORD_MIN, COORD_MAX, 63, COORD_MIN, 0,
                        COORD_MAX, COORD_MIN, 63, COORD_MAX, 0));
    send_wire(make_wire(COORD_MAX, 0, 0, COORD_MAX, HEIGHT_MAX,
                        COORD_MAX - 1, 0, 0, COORD_MAX, HEIGHT_MAX));
    send_wire(make_wire(COORD_MIN, COORD_MIN, 0, COORD_MIN, 0,
                        COORD_MIN, COORD_MIN, 0, COORD_MIN, 0));
  endtask

  task automatic test_config_extremes();
    set_router_config('0, '0, '0);
    send_wire(make_wire(0, 0, 3, -10*PX, 20*PX, 100*PX, 40*PX, 2, 30*PX, 20*PX));
    send_wire(make_wire(50*PX, 0, 10, -10*PX, 15*PX, 0, 40*PX, 10, 30*PX, 20*PX));
    // all ones, including the bits above the 12-bit registers
    set_router_config('1, '1, '1);
    send_wire(make_wire(0, 0, 3, -10*PX, 20*PX, 100*PX, 40*PX, 2, 30*PX, 20*PX));
    send_wire(make_wire(50*PX, 0, 63, -10*PX, 15*PX, 0, 40*PX, 63, 30*PX, 20*PX));
    send_wire(make_wire(COORD_MIN, COORD_MAX, 63, COORD_MIN, 0,
                        COORD_MAX, COORD_MIN, 63, COORD_MAX, 0));
    // index outside the register set must leave everything alone
    await_rects();
    write_reg(CFG_UNUSED_INDEX, cfg_word_t'($urandom));
    cfg_valid_i <= 1'b0;
    send_wire(make_wire(50*PX, 5*PX, 4, 0, 20*PX, 0, 8*PX, 1, 3*PX, 30*PX));
    // odd thickness, smallest nonzero pitch and stub
    set_router_config(16'd257, 16'd1, 16'd1);
    send_wire(make_wire(0, -1100, 7, -1001, 0, -PX, 50, 9, -2, 10));
  endtask

  task automatic test_random_wires();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_router_config(THICK_RESET, PITCH_RESET, STUB_RESET);
        1: set_router_config(cfg_word_t'($urandom_range(1, 2048)), cfg_word_t'($urandom),
                             cfg_word_t'($urandom));
        default: set_router_config(cfg_word_t'($urandom), cfg_word_t'($urandom),
                                   cfg_word_t'($urandom));
      endcase
      // last phase runs without any idle cycles on either side
      idle_on = (phase != 3);
      repeat (15) send_wire(random_wire());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_router_config(THICK_RESET, PITCH_RESET, STUB_RESET);
    holdoff_left = 100;
    repeat (15) send_wire(random_wire());
  endtask

  task automatic test_sender_pause();
    repeat (5) send_wire(random_wire());
    await_rects();
    repeat (5) send_wire(random_wire());
  endtask

  // receiver: long hold-off when asked, otherwise occasional stall cycles
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 99) < 10);
    end
  end

  task automatic note_mismatch(input string field, input logic [COORD_BITS-1:0] want_v,
                               input logic [COORD_BITS-1:0] got_v,
                               input logic [SEG_IDX_BITS-1:0] seg);
    $display("%0t ns: segment %0d %s expected %0h, got %0h", $time, seg, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_rects
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rects.size() == 0) begin
        $display("%0t ns: rectangle transfer with no wire pending, expected none, got %h",
                 $time, out_item_o);
        mismatches++;
      end else begin
        want = pending_rects.pop_front();
        if (out_item_o.rect_x !== want.rect_x)
          note_mismatch("rect_x", want.rect_x, out_item_o.rect_x, want.segment_index);
        if (out_item_o.rect_y !== want.rect_y)
          note_mismatch("rect_y", want.rect_y, out_item_o.rect_y, want.segment_index);
        if (out_item_o.rect_w !== want.rect_w)
          note_mismatch("rect_w", want.rect_w, out_item_o.rect_w, want.segment_index);
        if (out_item_o.rect_h !== want.rect_h)
          note_mismatch("rect_h", want.rect_h, out_item_o.rect_h, want.segment_index);
        if (out_item_o.segment_index !== want.segment_index)
          note_mismatch("segment_index", COORD_BITS'(want.segment_index),
                        COORD_BITS'(out_item_o.segment_index), want.segment_index);
        if (out_item_o.last !== want.last)
          note_mismatch("last", COORD_BITS'(want.last), COORD_BITS'(out_item_o.last),
                        want.segment_index);
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_routes();
    test_config_extremes();
    test_random_wires();
    test_output_backpressure();
    test_sender_pause();
    await_rects();
    repeat (12) @(negedge clk_i);
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
